FILE: src/format_insert_max_scanner_top_assert.svh
// Assertion macros shared by the format insert scanner RTL.
`ifndef FORMAT_INSERT_MAX_SCANNER_TOP_ASSERT_SVH
`define FORMAT_INSERT_MAX_SCANNER_TOP_ASSERT_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define FIMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define FIMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/fims_pkg.sv
// Types and constants shared by the format insert scanner modules.
package fims_pkg;

    localparam int CodeWidth   = 16;
    localparam int NumberWidth = 14;

    // Scan modes.
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_PERCENT = 2'd1;
    localparam logic [1:0] MODE_DIGITS  = 2'd2;
    localparam logic [1:0] MODE_SPEC    = 2'd3;

    // Code units with a special meaning.
    localparam logic [CodeWidth-1:0] CU_NUL     = 16'h0000;
    localparam logic [CodeWidth-1:0] CU_BANG    = 16'h0021;
    localparam logic [CodeWidth-1:0] CU_PERCENT = 16'h0025;
    localparam logic [CodeWidth-1:0] CU_ZERO    = 16'h0030;
    localparam logic [CodeWidth-1:0] CU_NINE    = 16'h0039;

    // Accumulation stops once the number reaches this value.
    localparam logic [NumberWidth-1:0] SAT_LIMIT  = 14'd1000;
    localparam logic [NumberWidth-1:0] MAX_INSERT = 14'd9999;

    // Scanner state carried from item to item.
    typedef struct packed {
        logic [1:0]             mode;
        logic [NumberWidth-1:0] acc;
        logic [NumberWidth-1:0] max;
    } t_scan;

    localparam t_scan SCAN_RESET = '{mode: MODE_PLAIN, acc: '0, max: '0};

endpackage

FILE: src/fims_step.sv
// Combinational next-state logic for one code unit of the format scanner.
module fims_step (
    input  fims_pkg::t_scan                      i_scan,
    input  logic [fims_pkg::CodeWidth-1:0]       i_code,
    output fims_pkg::t_scan                      o_scan,
    output logic                                 o_emit,
    output logic [fims_pkg::NumberWidth-1:0]     o_result
);
    import fims_pkg::*;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [NumberWidth-1:0] times_ten;
    logic [NumberWidth-1:0] closed_max;

    // Digit decode and the shift-add multiply by ten.
    assign is_digit   = (i_code >= CU_ZERO) && (i_code <= CU_NINE);
    assign digit      = i_code[3:0];
    assign times_ten  = {i_scan.acc[NumberWidth-4:0], 3'b000}
                      + {i_scan.acc[NumberWidth-2:0], 1'b0};
    // Maximum once the number being read is complete.
    assign closed_max = (i_scan.acc > i_scan.max) ? i_scan.acc : i_scan.max;

    // State step for one code unit.
    always_comb begin
        o_scan   = i_scan;
        o_emit   = 1'b0;
        o_result = i_scan.max;
        if (i_code == CU_NUL) begin
            // End of string: a pending number still counts, then start over.
            o_emit   = 1'b1;
            o_result = (i_scan.mode == MODE_DIGITS) ? closed_max : i_scan.max;
            o_scan   = SCAN_RESET;
        end else begin
            unique case (i_scan.mode)
                MODE_PERCENT: begin
                    if (is_digit) begin
                        o_scan.acc  = {{(NumberWidth-4){1'b0}}, digit};
                        o_scan.mode = MODE_DIGITS;
                    end else begin
                        o_scan.mode = MODE_PLAIN;
                    end
                end
                MODE_DIGITS: begin
                    if (is_digit) begin
                        if (i_scan.acc < SAT_LIMIT) begin
                            o_scan.acc = times_ten + {{(NumberWidth-4){1'b0}}, digit};
                        end
                    end else begin
                        // The terminating unit is rescanned as text unless it opens a spec.
                        o_scan.max = closed_max;
                        priority if (i_code == CU_BANG) begin
                            o_scan.mode = MODE_SPEC;
                        end else if (i_code == CU_PERCENT) begin
                            o_scan.mode = MODE_PERCENT;
                        end else begin
                            o_scan.mode = MODE_PLAIN;
                        end
                    end
                end
                MODE_SPEC: begin
                    if (i_code == CU_BANG) begin
                        o_scan.mode = MODE_PLAIN;
                    end
                end
                MODE_PLAIN: begin
                    if (i_code == CU_PERCENT) begin
                        o_scan.mode = MODE_PERCENT;
                    end
                end
            endcase
        end
    end

endmodule

FILE: src/format_insert_max_scanner_top.sv
// Top level of the format insert scanner: stream ports, state and result registers.
//
// The slave stream carries one UTF-16 code unit of a message-format string per
// transfer. Every code unit updates the scan state in the cycle it is taken; a
// NUL code unit ends the string and produces one transfer on the master stream
// holding the highest insert number seen (0 when the string had none), after
// which the scanner starts over on the next string.
// Throughput is one code unit per cycle unless a held result stalls the input. The
// state step is a single pass of compare, shift-add and select logic between the
// state registers. A result is on the master stream the cycle after taking its NUL.
// The result sits in an output register. While it waits, o_s_tready stays high
// only in a cycle where i_m_tready takes it, so a stalled receiver holds the
// input side after at most one pending result.
// Reset (synchronous, active low) returns the scanner to plain text with no
// pending number, a maximum of zero and an empty output register.
module format_insert_max_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] code_unit
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [13:0] highest_insert, [15:14] zero
);
    import fims_pkg::*;

    t_scan                  r_scan;
    t_scan                  n_scan;
    logic                   r_out_valid;
    logic [NumberWidth-1:0] r_out_data;
    logic                   step_emit;
    logic [NumberWidth-1:0] step_result;
    logic                   s_fire;

    // Input transfer when the output register is empty or is being emptied.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;

    fims_step u_step (
        .i_scan   (r_scan),
        .i_code   (i_s_tdata),
        .o_scan   (n_scan),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (s_fire) begin
            r_scan <= n_scan;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && step_emit) begin
            r_out_data <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};

    `include "format_insert_max_scanner_top_assert.svh"

    `FIMS_ASSERT_NEXT(a_nul_restarts,
        s_fire && (i_s_tdata == CU_NUL),
        o_m_tvalid && (r_scan.mode == MODE_PLAIN) && (r_scan.acc == '0) && (r_scan.max == '0),
        "NUL did not give a result and restart the scan")
    `FIMS_ASSERT_NEXT(a_text_no_result,
        s_fire && (i_s_tdata != CU_NUL),
        !o_m_tvalid,
        "a code unit other than NUL produced a result")
    `FIMS_ASSERT_NEXT(a_max_grows,
        s_fire && (i_s_tdata != CU_NUL),
        r_scan.max >= $past(r_scan.max),
        "running maximum dropped inside a string")
    `FIMS_ASSERT_NOW(a_range,
        1'b1,
        (r_scan.acc <= MAX_INSERT) && (r_scan.max <= MAX_INSERT),
        "insert number left its range")

endmodule
